@@ hw/rtl/mbf_pkg.sv @@
// Package: shared types, codes and length tables of the receive framer.
package mbf_pkg;

	localparam int unsigned MAX_FRAME_DEF = 260;
	localparam int unsigned QUEUE_DEPTH   = 2;

	localparam logic CMD_BYTE  = 1'b0;
	localparam logic CMD_ABORT = 1'b1;

	localparam logic [1:0] ST_PROGRESS = 2'd0;
	localparam logic [1:0] ST_COMPLETE = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;
	localparam logic [1:0] ST_TIMEOUT  = 2'd3;

	localparam logic [1:0] REG_HEADER    = 2'd0;
	localparam logic [1:0] REG_CHECKSUM  = 2'd1;
	localparam logic [1:0] REG_MAX_FRAME = 2'd2;
	localparam logic [1:0] REG_EXPECT    = 2'd3;

	localparam logic [7:0] FC_WRITE_COIL   = 8'd5;
	localparam logic [7:0] FC_WRITE_REG    = 8'd6;
	localparam logic [7:0] FC_WRITE_COILS  = 8'd15;
	localparam logic [7:0] FC_WRITE_REGS   = 8'd16;
	localparam logic [7:0] FC_REPORT_ID    = 8'd17;
	localparam logic [7:0] FC_MASK_WRITE   = 8'd22;
	localparam logic [7:0] FC_READ_WRITE   = 8'd23;
	localparam logic [7:0] FC_READ_INPUTS  = 8'd4;

	typedef enum logic [1:0] {
		PH_FUNC = 2'd0,
		PH_META = 2'd1,
		PH_DATA = 2'd2
	} phase_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic       frame_end;
		logic [7:0] byte_out;
		logic [8:0] byte_position;
		logic [8:0] frame_bytes;
		logic [7:0] function_seen;
	} out_item_t;

	// Classified request as it sits in the queue.
	typedef struct packed {
		logic       abort;
		logic [7:0] data;
	} q_item_t;

	// Length of the meta part after the function code.
	function automatic logic [3:0] meta_length(input logic [7:0] fc, input logic req);
		logic [3:0] m;
		if (req) begin
			if (fc <= FC_WRITE_REG) m = 4'd4;
			else if (fc == FC_WRITE_COILS || fc == FC_WRITE_REGS) m = 4'd5;
			else if (fc == FC_MASK_WRITE) m = 4'd6;
			else if (fc == FC_READ_WRITE) m = 4'd9;
			else m = 4'd0;
		end else begin
			if (fc == FC_WRITE_COIL || fc == FC_WRITE_REG ||
			    fc == FC_WRITE_COILS || fc == FC_WRITE_REGS) m = 4'd4;
			else if (fc == FC_MASK_WRITE) m = 4'd6;
			else m = 4'd1;
		end
		return m;
	endfunction

	// True when the last meta byte gives the data part's byte count.
	function automatic logic has_count(input logic [7:0] fc, input logic req);
		logic h;
		if (req) begin
			h = (fc == FC_WRITE_COILS) || (fc == FC_WRITE_REGS) || (fc == FC_READ_WRITE);
		end else begin
			h = (fc <= FC_READ_INPUTS) || (fc == FC_REPORT_ID) || (fc == FC_READ_WRITE);
		end
		return h;
	endfunction

endpackage

@@ hw/rtl/mbf_front.sv @@
// Front end: accepts and classifies requests into a short queue.
module mbf_front import mbf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_item,
	output logic     q_valid,
	output q_item_t  q_item,
	input  logic     q_pop
);

	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	q_item_t        q_mem_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           push;
	q_item_t        cls;

	assign in_stall = (cnt_q == CW'(QUEUE_DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != '0);
	assign q_item   = q_mem_q[rd_ptr_q];

	// Classify: an abort carries no byte.
	always_comb begin
		cls.abort = (in_item.cmd == CMD_ABORT);
		cls.data  = cls.abort ? 8'd0 : in_item.rx_byte;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/mbf_back.sv @@
// Back end: frame length tracking, configuration registers and result register.
module mbf_back import mbf_pkg::*; #(
	parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_data,
	input  logic      q_valid,
	input  q_item_t   q_item,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	localparam logic [8:0] MAX_LIM = 9'(MAX_FRAME);

	logic [2:0] header_q;
	logic [1:0] checksum_q;
	logic [8:0] max_frame_q;
	logic       expect_q;

	phase_t     phase_q, phase_n;
	logic [8:0] left_q, left_n;
	logic [8:0] so_far_q, so_far_n;
	logic [7:0] fc_q, fc_n;
	logic [7:0] cnt_q, cnt_n;

	logic       advance;
	logic [1:0] status;
	logic [8:0] pos;
	logic [3:0] meta_len;
	logic       meta_done;
	logic [8:0] data_len;
	logic [9:0] total;
	logic [8:0] limit;

	out_item_t  res;
	out_item_t  out_q;
	logic       out_valid_q;

	assign advance   = !out_valid_q || !out_stall;
	assign q_pop     = q_valid && advance;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign limit     = (max_frame_q < MAX_LIM) ? max_frame_q : MAX_LIM;

	// Next state of the framer for the request at the head of the queue.
	always_comb begin
		phase_n   = phase_q;
		left_n    = left_q;
		so_far_n  = so_far_q;
		fc_n      = fc_q;
		cnt_n     = cnt_q;
		status    = ST_PROGRESS;
		pos       = so_far_q;
		meta_done = 1'b0;
		meta_len  = '0;
		data_len  = '0;
		total     = '0;
		if (q_item.abort) begin
			status = ST_TIMEOUT;
		end else begin
			so_far_n = so_far_q + 9'd1;
			if (left_q != '0) left_n = left_q - 9'd1;
			if (phase_q == PH_META) cnt_n = q_item.data;
			if (phase_q == PH_FUNC && left_n == '0) fc_n = q_item.data;
			if (left_n == '0) begin
				if (phase_q == PH_FUNC) begin
					meta_len = meta_length(fc_n, expect_q);
					if (meta_len != '0) begin
						phase_n = PH_META;
						left_n  = 9'(meta_len);
					end else begin
						meta_done = 1'b1;
					end
				end else if (phase_q == PH_META) begin
					meta_done = 1'b1;
				end else begin
					status = ST_COMPLETE;
				end
				if (meta_done) begin
					data_len = (has_count(fc_n, expect_q) ? 9'(cnt_n) : 9'd0)
					           + 9'(checksum_q);
					total    = 10'(so_far_n) + 10'(data_len);
					if (total > 10'(limit)) begin
						status = ST_TOO_LONG;
					end else begin
						phase_n = PH_DATA;
						left_n  = data_len;
						if (data_len == '0) status = ST_COMPLETE;
					end
				end
			end
		end
	end

	// Result fields for the request.
	always_comb begin
		res.status        = status;
		res.frame_end     = (status != ST_PROGRESS);
		res.byte_out      = q_item.data;
		res.byte_position = q_item.abort ? 9'd0 : pos;
		res.frame_bytes   = so_far_n;
		res.function_seen = q_item.abort ? fc_q : fc_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q    <= 3'd1;
			checksum_q  <= 2'd2;
			max_frame_q <= 9'd256;
			expect_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEADER:    header_q    <= cfg_data[2:0];
				REG_CHECKSUM:  checksum_q  <= cfg_data[1:0];
				REG_MAX_FRAME: max_frame_q <= cfg_data;
				REG_EXPECT:    expect_q    <= cfg_data[0];
				default:       header_q    <= header_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FUNC;
			left_q   <= 9'd2;
			so_far_q <= '0;
			fc_q     <= '0;
			cnt_q    <= '0;
		end else if (q_pop) begin
			if (status != ST_PROGRESS) begin
				phase_q  <= PH_FUNC;
				left_q   <= 9'(header_q) + 9'd1;
				so_far_q <= '0;
				fc_q     <= '0;
				cnt_q    <= '0;
			end else begin
				phase_q  <= phase_n;
				left_q   <= left_n;
				so_far_q <= so_far_n;
				fc_q     <= fc_n;
				cnt_q    <= cnt_n;
			end
		end else if (cfg_we && cfg_index == REG_HEADER &&
		             so_far_q == '0 && phase_q == PH_FUNC) begin
			// Reload the header count while no byte of the frame has arrived.
			left_q <= 9'(cfg_data[2:0]) + 9'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q <= res;
		end
	end

endmodule

@@ hw/rtl/modbus_adu_receive_framer.sv @@
// A request is held in the queue and then registered in the result register before it shows at the output.
// Throughput: one request per cycle while the output does not stall; the back end's length update sets the pace.
// A two-entry queue lets input keep flowing for two requests while the output stalls.
// Reset (arst_n low, asynchronous) empties the queue and the result register, loads
// the register reset values and starts a new frame with the function phase.
// Top level: Modbus ADU receive framer.
module modbus_adu_receive_framer import mbf_pkg::*; #(
	parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_item,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_item,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_data
);

	// Queue head between front and back end.
	logic    q_valid;
	q_item_t q_item;
	logic    q_pop;

	// Front end: take each request, mark aborts, hold it in the queue.
	mbf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	// Back end: advance the framer state whenever the result register frees up,
	// so a waiting result never blocks the queue from filling.
	mbf_back #(
		.MAX_FRAME (MAX_FRAME)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

@@ hw/rtl/mbf_checker.sv @@
// Checker: port-level properties of the receive framer, bound to the top level.
module mbf_checker import mbf_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input out_item_t  out_item
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	a_end_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.frame_end == (out_item.status != ST_PROGRESS))
		else $error("frame_end disagrees with status");

	a_timeout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == ST_TIMEOUT |->
		out_item.byte_position == 9'd0 && out_item.byte_out == 8'd0)
		else $error("timeout result carries a byte");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != ST_TIMEOUT |->
		out_item.frame_bytes == out_item.byte_position + 9'd1)
		else $error("frame byte count out of step with position");

	a_first_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_item.frame_end ##1 out_valid &&
		out_item.status != ST_TIMEOUT |-> out_item.byte_position == 9'd0)
		else $error("frame after an end did not restart at position zero");

endmodule

bind modbus_adu_receive_framer mbf_checker u_mbf_checker (.*);

@@ tb/modbus_adu_receive_framer_tb.sv @@
// Testbench for the Modbus ADU receive framer: self-checking byte-stream framing test.
`timescale 1ns / 1ps

module modbus_adu_receive_framer_tb;
	import mbf_pkg::*;

	// Function codes that the package does not name but the stimulus needs.
	localparam logic [7:0] FC_READ_HOLDING = 8'd3;
	localparam logic [7:0] FC_UNLISTED     = 8'd99;

	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_AFTER  = 120;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_BACKLOG = 20;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_item;
	logic      cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_HEADER;
	logic [8:0] cfg_data = '0;

	modbus_adu_receive_framer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// Register copies as the framer should see them.
	logic [2:0] hdr_bytes;
	logic [1:0] chk_bytes;
	logic [8:0] max_bytes;
	logic       want_request;

	// Frame tracking state of the predictor.
	phase_t     frame_phase;
	logic [8:0] left_in_phase;
	logic [8:0] bytes_taken;
	logic [7:0] frame_fc;
	logic [7:0] last_meta;

	in_item_t  rx_stream[$];       // bytes and aborts waiting to be offered
	out_item_t awaited_results[$]; // framing results predicted but not yet seen

	int items_queued = 0;
	int results_seen = 0;
	int err_count = 0;
	int cycles = 0;

	// ---------------------------------------------------------------
	// Framing predictor
	// ---------------------------------------------------------------

	function automatic int meta_bytes_for(logic [7:0] fc, logic req);
		if (req) begin
			if (fc <= FC_WRITE_REG)
				return 4;
			case (fc)
				FC_WRITE_COILS, FC_WRITE_REGS: return 5;
				FC_MASK_WRITE:                 return 6;
				FC_READ_WRITE:                 return 9;
				default:                       return 0;
			endcase
		end
		case (fc)
			FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS: return 4;
			FC_MASK_WRITE:                                              return 6;
			default:                                                    return 1;
		endcase
	endfunction

	// True when the last meta byte carries the data byte count.
	function automatic logic counted_data(logic [7:0] fc, logic req);
		if (req)
			return fc == FC_WRITE_COILS || fc == FC_WRITE_REGS || fc == FC_READ_WRITE;
		return fc <= FC_READ_INPUTS || fc == FC_REPORT_ID || fc == FC_READ_WRITE;
	endfunction

	function automatic int frame_limit();
		return (int'(max_bytes) < MAX_FRAME_DEF) ? int'(max_bytes) : MAX_FRAME_DEF;
	endfunction

	function automatic void restart_frame();
		frame_phase   = PH_FUNC;
		left_in_phase = {6'd0, hdr_bytes} + 9'd1;
		bytes_taken   = '0;
		frame_fc      = '0;
		last_meta     = '0;
	endfunction

	// Advance the framer copy by one accepted request and queue its result.
	function automatic void predict_framing(in_item_t req);
		out_item_t  res;
		logic [1:0] st;
		logic [8:0] pos;
		logic [8:0] dlen;
		int         mlen;
		logic       meta_over;
		res = '0;
		st = ST_PROGRESS;
		meta_over = 1'b0;
		if (req.cmd == CMD_ABORT) begin
			// Abort reports what was dropped, even with no frame open.
			res.status        = ST_TIMEOUT;
			res.frame_end     = 1'b1;
			res.frame_bytes   = bytes_taken;
			res.function_seen = frame_fc;
			awaited_results.push_back(res);
			restart_frame();
			return;
		end
		pos = bytes_taken;
		bytes_taken = bytes_taken + 9'd1;
		if (left_in_phase != 0)
			left_in_phase = left_in_phase - 9'd1;
		if (frame_phase == PH_META)
			last_meta = req.rx_byte;
		if (frame_phase == PH_FUNC && left_in_phase == 0)
			frame_fc = req.rx_byte;
		if (left_in_phase == 0) begin
			if (frame_phase == PH_FUNC) begin
				mlen = meta_bytes_for(frame_fc, want_request);
				if (mlen != 0) begin
					frame_phase = PH_META;
					left_in_phase = 9'(mlen);
				end else begin
					// no meta part: size the data right off the function code
					meta_over = 1'b1;
				end
			end else if (frame_phase == PH_META) begin
				meta_over = 1'b1;
			end else begin
				// data phase, and the unused phase code behaves the same
				st = ST_COMPLETE;
			end
			if (meta_over) begin
				dlen = counted_data(frame_fc, want_request) ? {1'b0, last_meta} : 9'd0;
				dlen = dlen + {7'd0, chk_bytes};
				if (int'(bytes_taken) + int'(dlen) > frame_limit()) begin
					st = ST_TOO_LONG;
				end else begin
					frame_phase = PH_DATA;
					left_in_phase = dlen;
					if (dlen == 0)
						st = ST_COMPLETE;
				end
			end
		end
		res.status        = st;
		res.frame_end     = (st != ST_PROGRESS);
		res.byte_out      = req.rx_byte;
		res.byte_position = pos;
		res.frame_bytes   = bytes_taken;
		res.function_seen = frame_fc;
		awaited_results.push_back(res);
		if (st != ST_PROGRESS)
			restart_frame();
	endfunction

	// ---------------------------------------------------------------
	// Stimulus builders
	// ---------------------------------------------------------------

	function automatic void offer(logic cmd, logic [7:0] b);
		in_item_t it;
		it.cmd = cmd;
		it.rx_byte = b;
		rx_stream.push_back(it);
		items_queued++;
	endfunction

	// Queue one frame that fits the current settings; stop after the meta part
	// when the framer is going to reject it as too long.
	function automatic void queue_frame(logic [7:0] fc, logic [7:0] cnt);
		int mlen;
		int dlen;
		int total;
		mlen = meta_bytes_for(fc, want_request);
		dlen = counted_data(fc, want_request) ? int'(cnt) : 0;
		dlen += int'(chk_bytes);
		total = int'(hdr_bytes) + 1 + mlen + dlen;
		repeat (hdr_bytes) offer(CMD_BYTE, 8'($urandom_range(0, 255)));
		offer(CMD_BYTE, fc);
		for (int i = 1; i < mlen; i++)
			offer(CMD_BYTE, 8'($urandom_range(0, 255)));
		if (mlen != 0)
			offer(CMD_BYTE, cnt);
		if (total <= frame_limit())
			repeat (dlen) offer(CMD_BYTE, 8'($urandom_range(0, 255)));
	endfunction

	function automatic logic [7:0] pick_function();
		case ($urandom_range(0, 9))
			0: return FC_READ_HOLDING;
			1: return FC_READ_INPUTS;
			2: return FC_WRITE_COIL;
			3: return FC_WRITE_REG;
			4: return FC_WRITE_COILS;
			5: return FC_WRITE_REGS;
			6: return FC_REPORT_ID;
			7: return FC_MASK_WRITE;
			8: return FC_READ_WRITE;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Mostly short data parts, now and then a long one.
	function automatic logic [7:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return 8'($urandom_range(0, 10));
		if (r < 95)
			return 8'($urandom_range(11, 40));
		return 8'($urandom_range(41, 255));
	endfunction

	// Mostly whole frames with random content, the rest cut-off frames,
	// stray bytes and lone aborts.
	function automatic void queue_traffic(int n);
		int stop;
		int r;
		stop = items_queued + n;
		while (items_queued < stop) begin
			r = $urandom_range(0, 99);
			if (r < 72) begin
				queue_frame(pick_function(), pick_count());
			end else if (r < 84) begin
				repeat ($urandom_range(1, 6)) offer(CMD_BYTE, 8'($urandom_range(0, 255)));
				offer(CMD_ABORT, 8'($urandom_range(0, 255)));
			end else if (r < 95) begin
				repeat ($urandom_range(1, 4)) offer(CMD_BYTE, 8'($urandom_range(0, 255)));
			end else begin
				offer(CMD_ABORT, 8'($urandom_range(0, 255)));
			end
		end
	endfunction

	// Idle length: mostly none or short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// ---------------------------------------------------------------
	// Register writes and phase boundaries
	// ---------------------------------------------------------------

	task automatic write_reg(logic [1:0] idx, logic [8:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		// Mirror the write into the predictor once it has landed.
		case (idx)
			REG_HEADER: begin
				hdr_bytes = val[2:0];
				// reload the header count only when no byte of the frame is in
				if (bytes_taken == 0 && frame_phase == PH_FUNC)
					left_in_phase = {6'd0, hdr_bytes} + 9'd1;
			end
			REG_CHECKSUM:  chk_bytes = val[1:0];
			REG_MAX_FRAME: max_bytes = val;
			REG_EXPECT:    want_request = val[0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [2:0] hdr, logic [1:0] chk, logic [8:0] maxb, logic req);
		write_reg(REG_HEADER, {6'd0, hdr});
		write_reg(REG_CHECKSUM, {7'd0, chk});
		write_reg(REG_MAX_FRAME, maxb);
		write_reg(REG_EXPECT, {8'd0, req});
	endtask

	// Drain: sample at the falling edge so the driver and monitor have settled.
	task automatic settle();
		do
			@(negedge clk);
		while (rx_stream.size() != 0 || in_valid || awaited_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// Sequence of phases
	// ---------------------------------------------------------------

	initial begin
		// Register reset values, and a fresh frame.
		hdr_bytes = 3'd1;
		chk_bytes = 2'd2;
		max_bytes = 9'd256;
		want_request = 1'b0;
		restart_frame();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Serial-line responses at reset settings.
		// Abort with nothing open, then a read response with extreme bytes.
		offer(CMD_ABORT, 8'hFF);
		offer(CMD_BYTE, 8'hFF);
		offer(CMD_BYTE, FC_READ_HOLDING);
		offer(CMD_BYTE, 8'd2);
		offer(CMD_BYTE, 8'h00);
		offer(CMD_BYTE, 8'hFF);
		offer(CMD_BYTE, 8'h5A);
		offer(CMD_BYTE, 8'hA5);
		// Write response with a fixed meta part and no counted data.
		queue_frame(FC_WRITE_COIL, 8'd0);
		// Abort in the middle of a frame.
		offer(CMD_BYTE, 8'h01);
		offer(CMD_BYTE, FC_WRITE_REGS);
		offer(CMD_ABORT, 8'h00);
		queue_traffic(25);
		offer(CMD_ABORT, 8'h00);
		settle();

		// TCP server: longest header, no checksum, widest limit.
		// An unlisted request code has no meta part and an empty data part,
		// so the frame ends on the function byte.
		configure(3'd7, 2'd0, 9'd260, 1'b1);
		queue_frame(FC_UNLISTED, 8'd0);
		queue_frame(FC_READ_WRITE, 8'd4);
		queue_traffic(30);
		offer(CMD_ABORT, 8'h00);
		settle();

		// No header, tightest limit: every frame runs too long.
		configure(3'd0, 2'd2, 9'd2, 1'b0);
		queue_traffic(15);
		offer(CMD_ABORT, 8'h00);
		settle();

		// Short limit with requests, so long counts trip the check.
		configure(3'd3, 2'd1, 9'd20, 1'b1);
		queue_traffic(25);
		// Leave a frame open across the next header change.
		offer(CMD_BYTE, 8'h11);
		offer(CMD_BYTE, 8'h22);
		settle();

		// Header change mid-frame applies from the next frame on.
		configure(3'd2, 2'd1, 9'd100, 1'b0);
		queue_traffic(25);
		offer(CMD_ABORT, 8'h00);
		settle();

		// Largest frame that still fits, then more serial traffic.
		configure(3'd1, 2'd2, 9'd260, 1'b0);
		queue_frame(FC_READ_HOLDING, 8'd255);
		queue_traffic(15);
		settle();

		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// ---------------------------------------------------------------
	// Driver: offer queued requests with random gaps
	// ---------------------------------------------------------------

	int   send_gap;
	logic send_calm;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
			send_gap <= 0;
			send_calm <= 1'b0;
		end else begin
			// Predict on the request that this edge accepts.
			if (in_valid && !in_stall)
				predict_framing(in_item);
			// Hold the request while stalled; otherwise advance.
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (rx_stream.size() != 0) begin
					in_item <= rx_stream.pop_front();
					in_valid <= 1'b1;
					send_gap <= send_calm ? 0 : pick_gap();
					// switch between gappy and back-to-back stretches
					if ($urandom_range(0, 39) == 0)
						send_calm <= !send_calm;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: stall at random and check each accepted result
	// ---------------------------------------------------------------

	function automatic void check_result(out_item_t got);
		out_item_t want;
		results_seen++;
		if (awaited_results.size() == 0) begin
			err_count++;
			if (err_count <= 10)
				$display("%0t: unexpected result status %0d byte %0h pos %0d",
					$time, got.status, got.byte_out, got.byte_position);
			return;
		end
		want = awaited_results.pop_front();
		if (got.status !== want.status || got.frame_end !== want.frame_end ||
		    got.byte_out !== want.byte_out || got.byte_position !== want.byte_position ||
		    got.frame_bytes !== want.frame_bytes || got.function_seen !== want.function_seen) begin
			err_count++;
			if (err_count <= 10) begin
				$display("%0t: mismatch on result %0d (expected / actual)", $time, results_seen);
				$display("  status %0d/%0d end %0d/%0d byte %0h/%0h",
					want.status, got.status, want.frame_end, got.frame_end,
					want.byte_out, got.byte_out);
				$display("  pos %0d/%0d bytes %0d/%0d function %0d/%0d",
					want.byte_position, got.byte_position, want.frame_bytes,
					got.frame_bytes, want.function_seen, got.function_seen);
			end
		end
	endfunction

	int   hold_left;
	int   stall_left;
	logic take_calm;
	logic held_once;

	// Long hold-off: start it once enough requests wait to back up the input side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			held_once <= 1'b0;
		end else if (!held_once && results_seen >= HOLD_AFTER &&
		             rx_stream.size() > HOLD_BACKLOG) begin
			held_once <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
			take_calm <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				check_result(out_item);
			if (hold_left != 0) begin
				out_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				stall_left <= take_calm ? 0 : pick_gap();
				if ($urandom_range(0, 39) == 0)
					take_calm <= !take_calm;
			end
		end
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule
